### sv/sht_pkg.sv
// ----------------------------------------------------------------------------
// sht_pkg
// Shared types and codes of the SwissTable hash set engine.
// ----------------------------------------------------------------------------
package sht_pkg;

    localparam int ACTION_W = 2;
    localparam int HASH_W   = 64;
    localparam int CFG_W    = 4;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 10;
    localparam int COUNT_W  = 10;
    localparam int TAG_W    = 7;

    localparam logic [CFG_W-1:0] CFG_RESET    = 4'd10;
    localparam logic [CFG_W-1:0] CFG_MIN_LOG2 = 4'd2;

    localparam logic [7:0] CTRL_EMPTY   = 8'hFF;
    localparam logic [7:0] CTRL_DELETED = 8'h80;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_DONE      = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        S_WIPE,
        S_IDLE,
        S_F_RD,
        S_F_EV,
        S_R_RD,
        S_R_EV,
        S_J_RD,
        S_J_EV,
        S_INS,
        S_K_RD,
        S_K_EV,
        S_KEY_EV,
        S_L_RD,
        S_L_EV,
        S_T_RD,
        S_T_EV,
        S_ERASE,
        S_WR_TWIN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic idle;
        logic wiping;
        logic done;
    } core_stat_t;

    typedef struct packed {
        status_t              status;
        logic [SLOT_W-1:0]    slot;
        logic [COUNT_W-1:0]   item_count;
        logic [COUNT_W-1:0]   room_left;
    } res_t;

endpackage

### sv/sht_core.sv
// ----------------------------------------------------------------------------
// sht_core
// Probe sequencer with the control byte memory and the key memory.
// ----------------------------------------------------------------------------
module sht_core #(
    parameter int BUCKETS     = 1024,
    parameter int GROUP_BYTES = 8,
    parameter int KEY_BITS    = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic [sht_pkg::ACTION_W-1:0]          action,
    input  logic [sht_pkg::HASH_W-1:0]            hash,
    input  logic [KEY_BITS-1:0]                   key,
    input  logic                                  wipe_req,
    input  logic [$clog2(BUCKETS)-1:0]            mask,
    input  logic [$clog2(BUCKETS+1)-1:0]          b_total,
    input  logic [$clog2(BUCKETS+1)-1:0]          capacity,
    input  logic                                  res_take,
    output sht_pkg::core_stat_t                   stat,
    output sht_pkg::res_t                         res
);
    import sht_pkg::*;

    localparam int IW    = $clog2(BUCKETS);
    localparam int CW    = $clog2(BUCKETS + 1);
    localparam int DEPTH = BUCKETS + GROUP_BYTES;
    localparam int AW    = $clog2(DEPTH);
    localparam int GIW   = $clog2(GROUP_BYTES);
    localparam int LW    = $clog2(GROUP_BYTES + 1);

    logic [7:0]          ctrl_mem [DEPTH];
    logic [KEY_BITS-1:0] key_mem  [BUCKETS];
    logic [7:0]          ctrl_q;
    logic [KEY_BITS-1:0] key_q;

    logic                ctrl_we;
    logic [AW-1:0]       ctrl_waddr;
    logic [7:0]          ctrl_wdata;
    logic [AW-1:0]       ctrl_raddr;
    logic                key_we;
    logic [IW-1:0]       key_raddr;

    state_t              state_reg, state_next;
    action_t             action_reg, action_next;
    logic [HASH_W-1:0]   hash_reg, hash_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic                pend_reg, pend_next;
    logic [AW-1:0]       wcnt_reg, wcnt_next;
    logic [IW-1:0]       pos_reg, pos_next;
    logic [IW-1:0]       stride_reg, stride_next;
    logic [CW-1:0]       step_reg, step_next;
    logic [GIW-1:0]      i_reg, i_next;
    logic [GIW-1:0]      j_reg, j_next;
    logic [LW-1:0]       lead_reg, lead_next;
    logic [LW-1:0]       trail_reg, trail_next;
    logic [IW-1:0]       hit_reg, hit_next;
    logic [7:0]          old_reg, old_next;
    logic                hemp_reg, hemp_next;
    logic [7:0]          wval_reg, wval_next;
    status_t             status_reg, status_next;
    logic [IW-1:0]       slot_reg, slot_next;
    logic [CW-1:0]       live_reg, live_next;
    logic [CW-1:0]       room_reg, room_next;

    logic [AW-1:0]       abs_addr;
    logic [IW-1:0]       abs_idx;
    logic [IW-1:0]       stride_inc;
    logic [IW-1:0]       pos_adv;
    logic [IW-1:0]       prev_base;
    logic [AW-1:0]       twin_addr;
    logic [7:0]          tag_byte;

    always_ff @(posedge aclk) begin
        ctrl_q <= ctrl_mem[ctrl_raddr];
        if (ctrl_we) begin
            ctrl_mem[ctrl_waddr] <= ctrl_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        key_q <= key_mem[key_raddr];
        if (key_we) begin
            key_mem[hit_reg] <= key_reg;
        end
    end

    assign abs_addr   = AW'(pos_reg) + AW'(i_reg);
    assign abs_idx    = IW'(abs_addr) & mask;
    assign stride_inc = stride_reg + IW'(GROUP_BYTES);
    assign pos_adv    = (pos_reg + stride_inc) & mask;
    assign prev_base  = (hit_reg - IW'(GROUP_BYTES)) & mask;
    assign twin_addr  = AW'(prev_base) + AW'(GROUP_BYTES);
    assign tag_byte   = {1'b0, hash_reg[HASH_W-1 -: TAG_W]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_WIPE;
            pend_reg  <= 1'b0;
            wcnt_reg  <= '0;
            live_reg  <= '0;
            room_reg  <= '0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            wcnt_reg  <= wcnt_next;
            live_reg  <= live_next;
            room_reg  <= room_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg <= action_next;
        hash_reg   <= hash_next;
        key_reg    <= key_next;
        pos_reg    <= pos_next;
        stride_reg <= stride_next;
        step_reg   <= step_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        lead_reg   <= lead_next;
        trail_reg  <= trail_next;
        hit_reg    <= hit_next;
        old_reg    <= old_next;
        hemp_reg   <= hemp_next;
        wval_reg   <= wval_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
    end

    always_comb begin
        logic do_adv;
        logic adv_empty;
        do_adv      = 1'b0;
        adv_empty   = 1'b0;
        state_next  = state_reg;
        action_next = action_reg;
        hash_next   = hash_reg;
        key_next    = key_reg;
        pend_next   = pend_reg;
        wcnt_next   = wcnt_reg;
        pos_next    = pos_reg;
        stride_next = stride_reg;
        step_next   = step_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        lead_next   = lead_reg;
        trail_next  = trail_reg;
        hit_next    = hit_reg;
        old_next    = old_reg;
        hemp_next   = hemp_reg;
        wval_next   = wval_reg;
        status_next = status_reg;
        slot_next   = slot_reg;
        live_next   = live_reg;
        room_next   = room_reg;
        ctrl_we     = 1'b0;
        ctrl_waddr  = '0;
        ctrl_wdata  = CTRL_EMPTY;
        ctrl_raddr  = '0;
        key_we      = 1'b0;
        key_raddr   = '0;

        unique case (state_reg)
            S_WIPE: begin
                ctrl_we    = 1'b1;
                ctrl_waddr = wcnt_reg;
                ctrl_wdata = CTRL_EMPTY;
                if (wcnt_reg == AW'(DEPTH - 1)) begin
                    live_next   = '0;
                    room_next   = capacity;
                    status_next = STS_DONE;
                    slot_next   = '0;
                    state_next  = pend_reg ? S_DONE : S_IDLE;
                end else begin
                    wcnt_next = wcnt_reg + AW'(1);
                end
            end
            S_IDLE: begin
                if (start) begin
                    action_next = action_t'(action);
                    hash_next   = hash;
                    key_next    = key;
                    pend_next   = 1'b1;
                    wcnt_next   = '0;
                    pos_next    = IW'(hash) & mask;
                    stride_next = '0;
                    step_next   = '0;
                    i_next      = '0;
                    hemp_next   = 1'b0;
                    case (action_t'(action))
                        ACT_INSERT: state_next = S_F_RD;
                        ACT_LOOKUP: state_next = S_K_RD;
                        ACT_REMOVE: state_next = S_K_RD;
                        default:    state_next = S_WIPE;
                    endcase
                end
            end
            S_F_RD: begin
                ctrl_raddr = abs_addr;
                state_next = S_F_EV;
            end
            S_F_EV: begin
                if (ctrl_q[7]) begin
                    hit_next   = abs_idx;
                    state_next = S_R_RD;
                end else begin
                    do_adv = 1'b1;
                end
            end
            S_R_RD: begin
                ctrl_raddr = AW'(hit_reg);
                state_next = S_R_EV;
            end
            S_R_EV: begin
                if (ctrl_q[7]) begin
                    old_next   = ctrl_q;
                    state_next = S_INS;
                end else begin
                    j_next     = '0;
                    state_next = S_J_RD;
                end
            end
            S_J_RD: begin
                ctrl_raddr = AW'(j_reg);
                state_next = S_J_EV;
            end
            S_J_EV: begin
                if (ctrl_q[7]) begin
                    hit_next   = IW'(j_reg);
                    old_next   = ctrl_q;
                    state_next = S_INS;
                end else if (j_reg == GIW'(GROUP_BYTES - 1) ||
                             (CW'(j_reg) + CW'(1)) == b_total) begin
                    status_next = STS_FULL;
                    slot_next   = '0;
                    state_next  = S_DONE;
                end else begin
                    j_next     = j_reg + GIW'(1);
                    state_next = S_J_RD;
                end
            end
            S_INS: begin
                if (room_reg == '0 && old_reg[0]) begin
                    status_next = STS_FULL;
                    slot_next   = '0;
                    state_next  = S_DONE;
                end else begin
                    if (old_reg[0]) begin
                        room_next = room_reg - CW'(1);
                    end
                    ctrl_we     = 1'b1;
                    ctrl_waddr  = AW'(hit_reg);
                    ctrl_wdata  = tag_byte;
                    key_we      = 1'b1;
                    wval_next   = tag_byte;
                    live_next   = live_reg + CW'(1);
                    status_next = STS_DONE;
                    slot_next   = hit_reg;
                    state_next  = S_WR_TWIN;
                end
            end
            S_K_RD: begin
                ctrl_raddr = abs_addr;
                state_next = S_K_EV;
            end
            S_K_EV: begin
                hemp_next = hemp_reg | (ctrl_q == CTRL_EMPTY);
                if (ctrl_q == tag_byte) begin
                    hit_next   = abs_idx;
                    key_raddr  = abs_idx;
                    state_next = S_KEY_EV;
                end else begin
                    do_adv    = 1'b1;
                    adv_empty = hemp_reg | (ctrl_q == CTRL_EMPTY);
                end
            end
            S_KEY_EV: begin
                if (key_q == key_reg) begin
                    status_next = STS_DONE;
                    slot_next   = hit_reg;
                    if (action_reg == ACT_REMOVE) begin
                        lead_next  = '0;
                        state_next = S_L_RD;
                    end else begin
                        state_next = S_DONE;
                    end
                end else begin
                    do_adv    = 1'b1;
                    adv_empty = hemp_reg;
                end
            end
            S_L_RD: begin
                ctrl_raddr = AW'(prev_base) + AW'(GROUP_BYTES - 1) - AW'(lead_reg);
                state_next = S_L_EV;
            end
            S_L_EV: begin
                trail_next = '0;
                if (ctrl_q != CTRL_EMPTY) begin
                    lead_next = lead_reg + LW'(1);
                    state_next = (lead_reg == LW'(GROUP_BYTES - 1)) ? S_T_RD : S_L_RD;
                end else begin
                    state_next = S_T_RD;
                end
            end
            S_T_RD: begin
                ctrl_raddr = AW'(hit_reg) + AW'(trail_reg);
                state_next = S_T_EV;
            end
            S_T_EV: begin
                if (ctrl_q != CTRL_EMPTY) begin
                    trail_next = trail_reg + LW'(1);
                    state_next = (trail_reg == LW'(GROUP_BYTES - 1)) ? S_ERASE : S_T_RD;
                end else begin
                    state_next = S_ERASE;
                end
            end
            S_ERASE: begin
                ctrl_we    = 1'b1;
                ctrl_waddr = AW'(hit_reg);
                if (((LW+1)'(lead_reg) + (LW+1)'(trail_reg)) >=
                    (LW+1)'(GROUP_BYTES)) begin
                    ctrl_wdata = CTRL_DELETED;
                    wval_next  = CTRL_DELETED;
                end else begin
                    ctrl_wdata = CTRL_EMPTY;
                    wval_next  = CTRL_EMPTY;
                    room_next  = room_reg + CW'(1);
                end
                live_next  = live_reg - CW'(1);
                state_next = S_WR_TWIN;
            end
            S_WR_TWIN: begin
                ctrl_we    = 1'b1;
                ctrl_waddr = twin_addr;
                ctrl_wdata = wval_reg;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_take) begin
                    pend_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (do_adv) begin
            if (i_reg == GIW'(GROUP_BYTES - 1)) begin
                if (adv_empty || step_reg == b_total) begin
                    status_next = (action_reg == ACT_INSERT) ? STS_FULL : STS_NOT_FOUND;
                    slot_next   = '0;
                    state_next  = S_DONE;
                end else begin
                    step_next   = step_reg + CW'(1);
                    stride_next = stride_inc;
                    pos_next    = pos_adv;
                    i_next      = '0;
                    hemp_next   = 1'b0;
                    state_next  = (action_reg == ACT_INSERT) ? S_F_RD : S_K_RD;
                end
            end else begin
                i_next     = i_reg + GIW'(1);
                state_next = (action_reg == ACT_INSERT) ? S_F_RD : S_K_RD;
            end
        end

        if (wipe_req) begin
            wcnt_next  = '0;
            state_next = S_WIPE;
        end
    end

    assign stat.idle   = (state_reg == S_IDLE);
    assign stat.wiping = (state_reg == S_WIPE);
    assign stat.done   = (state_reg == S_DONE);

    assign res.status     = status_reg;
    assign res.slot       = SLOT_W'(slot_reg);
    assign res.item_count = COUNT_W'(live_reg);
    assign res.room_left  = COUNT_W'(room_reg);

endmodule

### sv/swisstable_hash_set_engine.sv
// ----------------------------------------------------------------------------
// swisstable_hash_set_engine
// Fixed-size SwissTable hash set with insert, lookup, remove and clear.
// ----------------------------------------------------------------------------
// One operation is worked at a time. Every control byte that a probe visits
// takes an address state and a registered read of the control memory, and a
// tag hit adds a read of the key memory. A remove adds a read of each byte of
// the empty-run test on both sides (up to twice GROUP_BYTES bytes) and two
// writes. After reset, after a configuration write and for a clear action
// the control memory is swept one entry a cycle, over all BUCKETS +
// GROUP_BYTES entries, while no word is accepted. The result word waits in
// an output register, so the next word is taken while it is still
// unclaimed.
module swisstable_hash_set_engine #(
    parameter int BUCKETS     = 1024,
    parameter int GROUP_BYTES = 8,
    parameter int KEY_BITS    = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [sht_pkg::ACTION_W-1:0]      s_action,
    input  logic [sht_pkg::HASH_W-1:0]        s_hash,
    input  logic [KEY_BITS-1:0]               s_key,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sht_pkg::STATUS_W-1:0]      m_status,
    output logic [sht_pkg::SLOT_W-1:0]        m_slot,
    output logic [sht_pkg::COUNT_W-1:0]       m_item_count,
    output logic [sht_pkg::COUNT_W-1:0]       m_room_left,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sht_pkg::CFG_W-1:0]         cfg_wdata
);
    import sht_pkg::*;

    localparam int IW = $clog2(BUCKETS);
    localparam int CW = $clog2(BUCKETS + 1);

    logic [CFG_W-1:0] cfg_reg;
    logic [CFG_W-1:0] log2_eff;
    logic [16:0]      pow_b;
    logic [CW-1:0]    b_total;
    logic [CW-1:0]    b_minus;
    logic [CW-1:0]    b_eighth;
    logic [CW-1:0]    capacity;
    logic [IW-1:0]    mask;

    core_stat_t       stat;
    res_t             res;
    res_t             out_reg;
    logic             m_valid_reg, m_valid_next;
    logic             start;
    logic             cfg_wr;
    logic             out_load;

    assign cfg_ready = stat.idle | stat.wiping;
    assign cfg_wr    = cfg_valid & cfg_ready;
    assign s_ready   = stat.idle & ~cfg_valid;
    assign start     = s_valid & s_ready;
    assign out_load  = stat.done & (~m_valid_reg | m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_wr) begin
            cfg_reg <= cfg_wdata;
        end
    end

    assign log2_eff = (cfg_reg < CFG_MIN_LOG2) ? CFG_MIN_LOG2 : cfg_reg;
    assign pow_b    = 17'(1) << log2_eff;
    assign b_total  = (pow_b > 17'(BUCKETS)) ? CW'(BUCKETS) : CW'(pow_b);
    assign b_minus  = b_total - CW'(1);
    assign b_eighth = b_total >> 3;
    assign capacity = (b_minus < CW'(8)) ? b_minus : ((b_eighth << 3) - b_eighth);
    assign mask     = IW'(b_minus);

    sht_core #(
        .BUCKETS     (BUCKETS),
        .GROUP_BYTES (GROUP_BYTES),
        .KEY_BITS    (KEY_BITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .action   (s_action),
        .hash     (s_hash),
        .key      (s_key),
        .wipe_req (cfg_wr),
        .mask     (mask),
        .b_total  (b_total),
        .capacity (capacity),
        .res_take (out_load),
        .stat     (stat),
        .res      (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = out_reg.status;
    assign m_slot       = out_reg.slot;
    assign m_item_count = out_reg.item_count;
    assign m_room_left  = out_reg.room_left;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> !stat.idle)
        else $error("engine still idle after taking a word");

    a_wipe_after_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> stat.wiping)
        else $error("configuration write did not start a clearing pass");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.done && !out_load) |=> stat.done)
        else $error("result dropped while the output register was full");

    a_load_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !out_load)
        else $error("output register overwritten before it was taken");

endmodule

### tb/sv/tb_swisstable_hash_set_engine.sv
// ----------------------------------------------------------------------------
// tb_swisstable_hash_set_engine
// Self-checking testbench of the SwissTable hash set engine: a directed table
// and random insert, lookup, remove and clear words, each result word checked
// against a behavioral copy of the hash set, over several bucket counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_swisstable_hash_set_engine;
    import sht_pkg::*;

    localparam int NB = 1024;
    localparam int GB = 8;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action = '0;
    logic [63:0] s_hash = '0;
    logic [31:0] s_key = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [9:0]  m_slot;
    logic [9:0]  m_item_count;
    logic [9:0]  m_room_left;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_wdata = '0;

    swisstable_hash_set_engine DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_hash(s_hash), .s_key(s_key),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status), .m_slot(m_slot),
        .m_item_count(m_item_count), .m_room_left(m_room_left),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Behavioral copy of the set.
    logic [3:0]  size_log2;
    logic [7:0]  ctrl_mem [NB+GB];
    logic [31:0] key_mem [NB];
    int unsigned live_n;
    int unsigned room_n;
    res_t        pending [$];
    int          errors = 0;
    int          send_idle = 0;
    int          recv_idle = 0;
    bit          waiting_result = 1'b0;

    function automatic int unsigned bucket_n();
        int unsigned n;
        n = (size_log2 < 2) ? 2 : size_log2;
        return ((1 << n) > NB) ? NB : (1 << n);
    endfunction

    function automatic void clear_set();
        int unsigned b;
        b = bucket_n();
        foreach (ctrl_mem[i]) ctrl_mem[i] = CTRL_EMPTY;
        live_n = 0;
        room_n = (b - 1 < 8) ? b - 1 : (b / 8) * 7;
    endfunction

    function automatic void write_ctrl_pair(int unsigned idx, int unsigned mask,
                                            logic [7:0] v);
        ctrl_mem[idx] = v;
        ctrl_mem[((idx - GB) & mask) + GB] = v;
    endfunction

    function automatic int find_free(logic [63:0] h, int unsigned b);
        int unsigned mask, pos, stride, r;
        mask = b - 1;
        pos = h[31:0] & mask;
        stride = 0;
        for (int unsigned s = 0; s <= b; s++) begin
            for (int unsigned i = 0; i < GB; i++) begin
                if (ctrl_mem[pos+i][7]) begin
                    r = (pos + i) & mask;
                    if (!ctrl_mem[r][7]) begin
                        for (int unsigned j = 0; j < GB && j < b; j++)
                            if (ctrl_mem[j][7]) return j;
                        return -1;
                    end
                    return r;
                end
            end
            stride += GB;
            pos = (pos + stride) & mask;
        end
        return -1;
    endfunction

    function automatic int find_entry(logic [63:0] h, logic [31:0] k, int unsigned b);
        int unsigned mask, pos, stride, r;
        bit seen_empty;
        mask = b - 1;
        pos = h[31:0] & mask;
        stride = 0;
        for (int unsigned s = 0; s <= b; s++) begin
            seen_empty = 1'b0;
            for (int unsigned i = 0; i < GB; i++) begin
                if (ctrl_mem[pos+i] == {1'b0, h[63:57]}) begin
                    r = (pos + i) & mask;
                    if (key_mem[r] == k) return r;
                end
                if (ctrl_mem[pos+i] == CTRL_EMPTY) seen_empty = 1'b1;
            end
            if (seen_empty) return -1;
            stride += GB;
            pos = (pos + stride) & mask;
        end
        return -1;
    endfunction

    function automatic void erase_entry(int unsigned idx, int unsigned b);
        int unsigned mask, prev, lead, trail;
        mask = b - 1;
        prev = (idx - GB) & mask;
        lead = 0;
        trail = 0;
        while (lead < GB && ctrl_mem[prev + GB - 1 - lead] != CTRL_EMPTY) lead++;
        while (trail < GB && ctrl_mem[idx + trail] != CTRL_EMPTY) trail++;
        if (lead + trail >= GB) begin
            write_ctrl_pair(idx, mask, CTRL_DELETED);
        end else begin
            room_n++;
            write_ctrl_pair(idx, mask, CTRL_EMPTY);
        end
        live_n--;
    endfunction

    function automatic res_t apply_word(action_t act, logic [63:0] h, logic [31:0] k);
        res_t        res;
        int          r;
        int unsigned b;
        b = bucket_n();
        res.status = STS_DONE;
        res.slot = '0;
        if (act == ACT_INSERT) begin
            r = find_free(h, b);
            if (r < 0) begin
                res.status = STS_FULL;
            end else if (room_n == 0 && ctrl_mem[r][0]) begin
                res.status = STS_FULL;
            end else begin
                if (ctrl_mem[r][0]) room_n--;
                write_ctrl_pair(r, b - 1, {1'b0, h[63:57]});
                key_mem[r] = k;
                live_n++;
                res.slot = r[9:0];
            end
        end else if (act == ACT_LOOKUP || act == ACT_REMOVE) begin
            r = find_entry(h, k, b);
            if (r < 0) begin
                res.status = STS_NOT_FOUND;
            end else begin
                res.slot = r[9:0];
                if (act == ACT_REMOVE) erase_entry(r, b);
            end
        end else begin
            clear_set();
        end
        res.item_count = live_n[9:0];
        res.room_left = room_n[9:0];
        return res;
    endfunction

    task automatic send_word(action_t act, logic [63:0] h, logic [31:0] k);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_hash <= h;
        s_key <= k;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending.push_back(apply_word(act, h, k));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_size(logic [3:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        size_log2 = v;
        clear_set();
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                res_t e;
                e = pending.pop_front();
                if (m_status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, m_status);
                    errors++;
                end
                if (m_slot !== e.slot) begin
                    $error("slot expected %0d actual %0d", e.slot, m_slot);
                    errors++;
                end
                if (m_item_count !== e.item_count) begin
                    $error("item_count expected %0d actual %0d", e.item_count, m_item_count);
                    errors++;
                end
                if (m_room_left !== e.room_left) begin
                    $error("room_left expected %0d actual %0d", e.room_left, m_room_left);
                    errors++;
                end
            end
        end
        if (aresetn) m_ready <= ($urandom_range(99) >= recv_idle);
    end

    typedef struct {
        action_t     act;
        logic [63:0] h;
        logic [31:0] k;
        bit          known;
        res_t        res;
    } dir_row_t;

    dir_row_t dir_rows [$];

    function automatic dir_row_t row(action_t a, logic [63:0] h, logic [31:0] k, bit kn,
                                     status_t st, int sl, int cnt, int rm);
        dir_row_t d;
        d.act = a;
        d.h = h;
        d.k = k;
        d.known = kn;
        d.res.status = st;
        d.res.slot = 10'(sl);
        d.res.item_count = 10'(cnt);
        d.res.room_left = 10'(rm);
        return d;
    endfunction

    logic [31:0] key_pool [16];
    logic [63:0] hash_pool [16];

    task automatic random_phase(int n, int lg);
        action_t a;
        int      p;
        logic [63:0] h;
        logic [31:0] k;
        write_size(lg[3:0]);
        foreach (key_pool[i]) begin
            key_pool[i] = $urandom;
            hash_pool[i] = {$urandom, $urandom};
            if ($urandom_range(1)) hash_pool[i][9:0] = hash_pool[0][9:0];
        end
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(99);
            a = (p < 45) ? ACT_INSERT : (p < 72) ? ACT_LOOKUP : (p < 99) ? ACT_REMOVE
                                                                        : ACT_CLEAR;
            if ($urandom_range(9) < 8) begin
                p = $urandom_range(15);
                h = hash_pool[p];
                k = key_pool[p];
            end else begin
                h = {$urandom, $urandom};
                k = $urandom;
            end
            if (i == n / 2) drain();
            send_word(a, h, k);
        end
    endtask

    initial begin
        dir_row_t d;
        size_log2 = 4'd10;
        clear_set();
        foreach (key_mem[i]) key_mem[i] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        dir_rows.push_back(row(ACT_LOOKUP, 64'h0, 32'h0, 1, STS_NOT_FOUND, 0, 0, 896));
        dir_rows.push_back(row(ACT_INSERT, 64'h0, 32'h0, 1, STS_DONE, 0, 1, 895));
        dir_rows.push_back(row(ACT_INSERT, '1, '1, 1, STS_DONE, 1023, 2, 894));
        dir_rows.push_back(row(ACT_LOOKUP, '1, '1, 1, STS_DONE, 1023, 2, 894));
        dir_rows.push_back(row(ACT_INSERT, '1, '1, 0, STS_DONE, 0, 0, 0));
        dir_rows.push_back(row(ACT_REMOVE, '1, '1, 0, STS_DONE, 0, 0, 0));
        dir_rows.push_back(row(ACT_LOOKUP, '1, 32'h1, 1, STS_NOT_FOUND, 0, 2, 894));
        dir_rows.push_back(row(ACT_REMOVE, 64'h0, 32'h0, 0, STS_DONE, 0, 0, 0));
        dir_rows.push_back(row(ACT_INSERT, 64'h5555_AAAA_5555_AAAA, 32'hAAAA_5555, 0,
                               STS_DONE, 0, 0, 0));
        dir_rows.push_back(row(ACT_CLEAR, 64'h0, 32'h0, 1, STS_DONE, 0, 0, 896));
        foreach (dir_rows[i]) begin
            d = dir_rows[i];
            send_word(d.act, d.h, d.k);
            if (d.known && pending[$] != d.res) begin
                $error("table row %0d: model disagrees with typed result", i);
                errors++;
            end
        end

        // Smallest table: three entries fill it, the fourth and fifth are rejected.
        write_size(4'd0);
        for (int i = 0; i < 5; i++) send_word(ACT_INSERT, {$urandom, $urandom}, $urandom);
        send_word(ACT_REMOVE, 64'h0, 32'h0);
        write_size(4'd15);
        send_word(ACT_INSERT, 64'h0, 32'h0);

        send_idle = 16;
        recv_idle = 78;
        random_phase(300, 2);
        random_phase(350, 4);
        send_idle = 78;
        recv_idle = 16;
        random_phase(300, 3);
        random_phase(350, 6);
        send_idle = 0;
        recv_idle = 0;
        random_phase(300, 5);
        random_phase(330, 10);

        drain();
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
